>>> hw/rtl/fictitious_play_best_response_assert.svh
// Assertion macros used by the fictitious-play best-response port checker.
// Each macro expands to one labeled concurrent assertion with a clock and reset.
`ifndef FICTITIOUS_PLAY_BEST_RESPONSE_ASSERT_SVH
`define FICTITIOUS_PLAY_BEST_RESPONSE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPBR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPBR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/fpbr_pkg.sv
// Shared types, constants and codes for the fictitious-play best-response block.
// Used by fpbr_score, the top level and the port checker.
package fpbr_pkg;

   localparam int MAX_ROWS    = 16;
   localparam int MAX_COLS    = 16;
   localparam int PAYOFF_BITS = 16;
   localparam int MOVE_DEPTH  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int IDX_W       = $clog2(MOVE_DEPTH);
   localparam int ADDR_W      = $clog2(MAX_ROWS * MAX_COLS);
   localparam int COUNT_W     = 16;
   localparam int PROD_W      = PAYOFF_BITS + COUNT_W + 1;
   localparam int ACC_W       = PROD_W + IDX_W;
   localparam int SCORE_W     = 36;
   localparam int SAT_W       = (ACC_W > SCORE_W) ? ACC_W : SCORE_W;
   localparam int PAY_W       = 40;
   localparam int PAY_EXT_W   = PAY_W + 1;
   localparam int CFG_N_W     = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int PICK_W      = 4;

   localparam logic signed [SCORE_W-1:0] SCORE_HI = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_LO = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic signed [PAY_W-1:0]   PAY_HI   = {1'b0, {(PAY_W-1){1'b1}}};
   localparam logic signed [PAY_W-1:0]   PAY_LO   = {1'b1, {(PAY_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_RECORD = 2'd1,
      OP_CHOOSE = 2'd2,
      OP_ADD    = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IS_ROW   = 2'd0,
      CSR_NUM_ROWS = 2'd1,
      CSR_NUM_COLS = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // request tdata, last field in the low bits
   typedef struct packed {
      logic [3:0]         pad;
      logic [3:0]         fallback_pick;
      logic signed [15:0] item_value;
      logic [3:0]         col_index;
      logic [3:0]         row_index;
   } req_data_type;

   // result tdata, last field in the low bits
   typedef struct packed {
      logic signed [PAY_W-1:0]   running_payoff;
      logic signed [SCORE_W-1:0] best_score;
      logic [PICK_W-1:0]         chosen_strategy;
   } rsp_data_type;

   typedef struct packed {
      logic                          en;
      logic [ADDR_W-1:0]             addr;
      logic signed [PAYOFF_BITS-1:0] data;
   } mem_wr_type;

   // one matrix element on its way through read, multiply and accumulate
   typedef struct packed {
      logic               valid;
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] count;
      logic               first_inner;
      logic               last_inner;
      logic               first_outer;
      logic               last_outer;
      logic [IDX_W-1:0]   outer;
   } issue_type;

   typedef struct packed {
      logic                      done;
      logic [IDX_W-1:0]          pick;
      logic signed [SCORE_W-1:0] score;
   } score_type;

endpackage

>>> hw/rtl/fpbr_score.sv
// Payoff matrix memory and the multiply-accumulate path that scores strategies.
// Depends on fpbr_pkg. A registered memory read, then multiply and accumulate stages.
module fpbr_score (
   input  logic                clock,
   input  logic                reset,
   input  logic                is_row,
   input  fpbr_pkg::mem_wr_type wr,
   input  fpbr_pkg::issue_type  iss,
   output fpbr_pkg::score_type  res
);
   import fpbr_pkg::*;

   logic signed [PAYOFF_BITS-1:0] mem [MAX_ROWS * MAX_COLS];
   logic signed [PAYOFF_BITS-1:0] rd_ff;
   issue_type                     s1_ff, s2_ff;
   logic signed [PROD_W-1:0]      prod_in, prod_ff;
   logic signed [ACC_W-1:0]       acc_ff, sum_in, best_ff;
   logic [IDX_W-1:0]              pick_ff;
   logic                          done_ff;
   logic                          better;
   logic signed [SAT_W-1:0]       best_wide;

   // writes only happen while idle, read data is only used while scoring: no overlap
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_ff <= mem[iss.addr];
   end

   assign prod_in = rd_ff * $signed({1'b0, s1_ff.count});
   assign sum_in  = (s2_ff.first_inner ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);
   assign better  = s2_ff.first_outer || (is_row ? (sum_in > best_ff) : (sum_in < best_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_ff   <= iss;
         s2_ff   <= s1_ff;
         done_ff <= s2_ff.valid && s2_ff.last_inner && s2_ff.last_outer;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s2_ff.valid) begin
         acc_ff <= sum_in;
         if (s2_ff.last_inner && better) begin
            best_ff <= sum_in;
            pick_ff <= s2_ff.outer;
         end
      end
   end

   assign best_wide = SAT_W'(best_ff);

   always_comb begin
      res.done = done_ff;
      res.pick = pick_ff;
      if (best_wide > SAT_W'(SCORE_HI)) begin
         res.score = SCORE_HI;
      end else if (best_wide < SAT_W'(SCORE_LO)) begin
         res.score = SCORE_LO;
      end else begin
         res.score = SCORE_W'(best_wide);
      end
   end

endmodule

>>> hw/rtl/fictitious_play_best_response.sv
// Fictitious-play best response. Load, record and add are accepted back to back.
// A choose with history walks rows*cols elements through the one memory read port and MAC;
// no input is taken until its result is registered. Without history the result takes
// the fallback pick with a zero score. A result still waiting when a choose finishes
// holds that choose, and all input, until it is taken.
// Synchronous active-high reset clears counts, history and payoff and resets config; matrix is kept.
module fictitious_play_best_response (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // row_index, col_index, item_value, fallback_pick, zero pad
   input  logic [31:0]                   req_tdata,
   // op
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // chosen_strategy, best_score, running_payoff
   output logic [79:0]                   rsp_tdata,
   // no_history
   output logic                          rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fpbr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fpbr_pkg::CFG_N_W-1:0]   csr_data
);
   import fpbr_pkg::*;

   req_data_type        req_view;
   op_type              op;
   logic                req_xfer;
   state_type           state_ff, state_in;

   logic                is_row_ff;
   logic [CFG_N_W-1:0]  num_rows_ff, num_cols_ff;
   logic [IDX_W-1:0]    rows_last, cols_last, outer_last, inner_last;

   logic [COUNT_W-1:0]  cnt_ff [MOVE_DEPTH];
   logic                hist_ff;
   logic signed [PAY_W-1:0]     pay_ff;
   logic signed [PAY_EXT_W-1:0] pay_sum;

   logic [IDX_W-1:0]    outer_ff, inner_ff;
   logic                issuing_ff;
   logic                nohist_ff;
   logic [PICK_W-1:0]   fallback_ff;

   logic                rsp_valid_ff;
   rsp_data_type        rsp_data_ff;
   logic                rsp_nohist_ff;
   logic                load_rsp;

   logic                move_ok;
   logic [IDX_W-1:0]    move_idx;
   logic [IDX_W-1:0]    row_sel, col_sel;

   mem_wr_type          wr;
   issue_type           iss;
   score_type           res;

   assign req_view  = req_tdata;
   assign op        = op_type'(req_tuser);
   assign req_xfer  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         is_row_ff   <= 1'b1;
         num_rows_ff <= CFG_N_W'(16);
         num_cols_ff <= CFG_N_W'(16);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IS_ROW:   is_row_ff   <= csr_data[0];
            CSR_NUM_ROWS: num_rows_ff <= csr_data;
            CSR_NUM_COLS: num_cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // strategy counts clipped into 1..MAX
   always_comb begin
      if (num_rows_ff == '0) begin
         rows_last = '0;
      end else if (32'(num_rows_ff) > MAX_ROWS) begin
         rows_last = IDX_W'(MAX_ROWS - 1);
      end else begin
         rows_last = IDX_W'(num_rows_ff - CFG_N_W'(1));
      end
      if (num_cols_ff == '0) begin
         cols_last = '0;
      end else if (32'(num_cols_ff) > MAX_COLS) begin
         cols_last = IDX_W'(MAX_COLS - 1);
      end else begin
         cols_last = IDX_W'(num_cols_ff - CFG_N_W'(1));
      end
   end

   assign outer_last = is_row_ff ? rows_last : cols_last;
   assign inner_last = is_row_ff ? cols_last : rows_last;

   // matrix load
   always_comb begin
      wr.en   = req_xfer && (op == OP_LOAD) &&
                (32'(req_view.row_index) < MAX_ROWS) && (32'(req_view.col_index) < MAX_COLS);
      wr.addr = ADDR_W'(req_view.row_index) * ADDR_W'(MAX_COLS) + ADDR_W'(req_view.col_index);
      wr.data = PAYOFF_BITS'(req_view.item_value);
   end

   // opponent move counts
   assign move_ok  = (req_view.item_value >= 0) && (req_view.item_value < MOVE_DEPTH);
   assign move_idx = IDX_W'(req_view.item_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MOVE_DEPTH; k++) begin
            cnt_ff[k] <= '0;
         end
         hist_ff <= 1'b0;
      end else if (req_xfer && (op == OP_RECORD) && move_ok) begin
         if (cnt_ff[move_idx] != '1) begin
            cnt_ff[move_idx] <= cnt_ff[move_idx] + COUNT_W'(1);
         end
         hist_ff <= 1'b1;
      end
   end

   // running payoff, saturating
   assign pay_sum = is_row_ff ? PAY_EXT_W'(pay_ff) + PAY_EXT_W'(req_view.item_value)
                              : PAY_EXT_W'(pay_ff) - PAY_EXT_W'(req_view.item_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         pay_ff <= '0;
      end else if (req_xfer && (op == OP_ADD)) begin
         if (pay_sum > PAY_EXT_W'(PAY_HI)) begin
            pay_ff <= PAY_HI;
         end else if (pay_sum < PAY_EXT_W'(PAY_LO)) begin
            pay_ff <= PAY_LO;
         end else begin
            pay_ff <= PAY_W'(pay_sum);
         end
      end
   end

   // state machine: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (op == OP_CHOOSE)) begin
               state_in = hist_ff ? ST_RUN : ST_FINISH;
            end
         end
         ST_RUN: begin
            if (res.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state machine: outputs
   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_RUN:    ;
         ST_FINISH: load_rsp = !rsp_valid_ff || rsp_tready;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // element sequencer: inner index walks the opponent counts
   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
      end else if (req_xfer && (op == OP_CHOOSE)) begin
         issuing_ff <= hist_ff;
         outer_ff   <= '0;
         inner_ff   <= '0;
      end else if (issuing_ff) begin
         if (inner_ff == inner_last) begin
            inner_ff <= '0;
            if (outer_ff == outer_last) begin
               issuing_ff <= 1'b0;
            end else begin
               outer_ff <= outer_ff + IDX_W'(1);
            end
         end else begin
            inner_ff <= inner_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && (op == OP_CHOOSE)) begin
         nohist_ff   <= !hist_ff;
         fallback_ff <= req_view.fallback_pick;
      end
   end

   assign row_sel = is_row_ff ? outer_ff : inner_ff;
   assign col_sel = is_row_ff ? inner_ff : outer_ff;

   always_comb begin
      iss.valid       = issuing_ff;
      iss.addr        = ADDR_W'(row_sel) * ADDR_W'(MAX_COLS) + ADDR_W'(col_sel);
      iss.count       = cnt_ff[inner_ff];
      iss.first_inner = (inner_ff == '0);
      iss.last_inner  = (inner_ff == inner_last);
      iss.first_outer = (outer_ff == '0);
      iss.last_outer  = (outer_ff == outer_last);
      iss.outer       = outer_ff;
   end

   fpbr_score u_score (
      .clock  (clock),
      .reset  (reset),
      .is_row (is_row_ff),
      .wr     (wr),
      .iss    (iss),
      .res    (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_nohist_ff                  <= nohist_ff;
         rsp_data_ff.running_payoff     <= pay_ff;
         if (nohist_ff) begin
            rsp_data_ff.chosen_strategy <= fallback_ff;
            rsp_data_ff.best_score      <= '0;
         end else begin
            rsp_data_ff.chosen_strategy <= PICK_W'(res.pick);
            rsp_data_ff.best_score      <= res.score;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_nohist_ff;

endmodule

>>> hw/rtl/fpbr_checker.sv
// Port-level checks for fictitious_play_best_response, bound to the top level.
// Depends on fpbr_pkg and fictitious_play_best_response_assert.svh.
`include "fictitious_play_best_response_assert.svh"

module fpbr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [1:0]                    req_tuser,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [79:0]                   rsp_tdata,
   input logic                          rsp_tuser
);
   import fpbr_pkg::*;

   rsp_data_type rsp_view;
   logic         choose_xfer;
   logic         other_xfer;

   assign rsp_view    = rsp_tdata;
   assign choose_xfer = req_tvalid && req_tready && (req_tuser == OP_CHOOSE);
   assign other_xfer  = req_tvalid && req_tready && (req_tuser != OP_CHOOSE);

   `FPBR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   `FPBR_ASSERT_SAME(a_fallback_zero, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_view.best_score == '0, "fallback result with nonzero score")

   `FPBR_ASSERT_NEXT(a_choose_busy, clock, reset, choose_xfer,
      !req_tready, "input taken right after a choose transfer")

   `FPBR_ASSERT_NEXT(a_single_cycle_ops, clock, reset, other_xfer,
      req_tready, "single-cycle op left the input blocked")

endmodule

bind fictitious_play_best_response fpbr_checker u_fpbr_checker (.*);
